@@ src/sch_pkg.sv @@
// shared types, widths and helpers of the segment circle hit test
`default_nettype none
package sch_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_z;
        logic [RAD_WIDTH-1:0]          radius;
    } t_in;

    typedef struct packed {
        logic hit;
        logic degenerate;
    } t_out;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] v_x;
        logic signed [COORD_WIDTH-1:0] v_y;
        logic signed [COORD_WIDTH-1:0] v_z;
        logic signed [COORD_WIDTH-1:0] d_x;
        logic signed [COORD_WIDTH-1:0] d_y;
        logic signed [COORD_WIDTH-1:0] d_z;
        logic [RAD_WIDTH-1:0]          radius;
        logic                          degenerate;
    } t_work;

    function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH-1:0] x);
        logic [COORD_WIDTH-1:0] u;
        u = x;
        return u[COORD_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction
endpackage
`default_nettype wire

@@ src/segment_circle_hit_test.sv @@
// segment against circle hit test, top level
// throughput: one transaction per cycle, paced by the fully pipelined back end
// the 64-stage square root of the cross product length sets the latency
// busy rises only when the internal queue nears full; the receiver cannot stall
// synchronous reset clears all valid state; no transaction survives reset
`default_nettype none
module segment_circle_hit_test #(
    parameter int DEPTH = sch_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire sch_pkg::t_in i_item,
    output logic              o_done,
    output sch_pkg::t_out     o_result
);
    import sch_pkg::*;

    logic  push;
    t_work f_work;
    t_work q_work;
    logic  q_empty;
    logic  q_afull;

    assign busy = q_afull;

    sch_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_item   (i_item),
        .o_push   (push),
        .o_work   (f_work)
    );

    sch_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_work        (f_work),
        .i_pop         (1'b1),
        .o_empty       (q_empty),
        .o_almost_full (q_afull),
        .o_work        (q_work)
    );

    sch_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_work   (q_work),
        .o_done   (o_done),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

@@ src/sch_mult.sv @@
// two stage unsigned multiplier built from four half width partial products
`default_nettype none
module sch_mult #(
    parameter int W = 32
) (
    input  wire logic           i_clk,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic [2*W-1:0]      o_p
);
    localparam int LO = W / 2;
    localparam int HI = W - LO;

    logic [2*LO-1:0]    r_ll;
    logic [LO+HI-1:0]   r_lh;
    logic [LO+HI-1:0]   r_hl;
    logic [2*HI-1:0]    r_hh;
    logic [LO+HI:0]     mid;

    always_ff @(posedge i_clk) begin
        r_ll <= (2*LO)'(i_a[LO-1:0]) * (2*LO)'(i_b[LO-1:0]);
        r_lh <= (LO+HI)'(i_a[LO-1:0]) * (LO+HI)'(i_b[W-1:LO]);
        r_hl <= (LO+HI)'(i_a[W-1:LO]) * (LO+HI)'(i_b[LO-1:0]);
        r_hh <= (2*HI)'(i_a[W-1:LO]) * (2*HI)'(i_b[W-1:LO]);
    end

    assign mid = (LO+HI+1)'(r_lh) + (LO+HI+1)'(r_hl);

    always_ff @(posedge i_clk) begin
        o_p <= {r_hh, r_ll} + ((2*W)'(mid) << LO);
    end
endmodule
`default_nettype wire

@@ src/sch_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none
module sch_sqrt #(
    parameter int OW = 32
) (
    input  wire logic            i_clk,
    input  wire logic [2*OW-1:0] i_n,
    output logic [OW-1:0]        o_root
);
    localparam int IW = 2 * OW;
    localparam int RW = OW + 2;

    logic [RW-1:0] r_rem  [OW];
    logic [OW-1:0] r_root [OW];
    logic [IW-1:0] r_n    [OW];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [RW-1:0] p_rem;
        logic [OW-1:0] p_root;
        logic [IW-1:0] p_n;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = i_n;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_n    = r_n[k-1];
        end

        assign rem_sh = {p_rem[RW-3:0], p_n[IW-1:IW-2]};
        assign trial  = {p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            r_n[k] <= p_n << 2;
            if (rem_sh >= trial) begin
                r_rem[k]  <= rem_sh - trial;
                r_root[k] <= {p_root[OW-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh;
                r_root[k] <= {p_root[OW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[OW-1];
endmodule
`default_nettype wire

@@ src/sch_delay.sv @@
// fixed length register delay line for payload alignment
`default_nettype none
module sch_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic [W-1:0]      o_q
);
    logic [W-1:0] r_d [N];

    always_ff @(posedge i_clk) begin
        r_d[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_d[k] <= r_d[k-1];
        end
    end

    assign o_q = r_d[N-1];
endmodule
`default_nettype wire

@@ src/sch_queue.sv @@
// small transaction queue between front and back
`default_nettype none
module sch_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sch_pkg::t_work i_work,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic                o_almost_full,
    output sch_pkg::t_work      o_work
);
    import sch_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_work        r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_empty       = (r_cnt == '0);
    assign o_almost_full = (r_cnt >= (AW+1)'(DEPTH - 1));
    assign o_work        = r_mem[r_rd];
    assign do_pop        = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

@@ src/sch_front.sv @@
// front end: accepts transactions, forms saturated differences and the degenerate flag
`default_nettype none
module sch_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire sch_pkg::t_in i_item,
    output logic              o_push,
    output sch_pkg::t_work    o_work
);
    import sch_pkg::*;
    localparam int CW = COORD_WIDTH;

    function automatic logic signed [CW-1:0] sat_diff(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        if (d[CW] != d[CW-1]) begin
            return d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return d[CW-1:0];
    endfunction

    t_work n_work;

    always_comb begin
        n_work.v_x        = sat_diff(i_item.end_x, i_item.start_x);
        n_work.v_y        = sat_diff(i_item.end_y, i_item.start_y);
        n_work.v_z        = sat_diff(i_item.end_z, i_item.start_z);
        n_work.d_x        = sat_diff(i_item.center_x, i_item.start_x);
        n_work.d_y        = sat_diff(i_item.center_y, i_item.start_y);
        n_work.d_z        = sat_diff(i_item.center_z, i_item.start_z);
        n_work.radius     = i_item.radius;
        n_work.degenerate = (i_item.start_x == i_item.end_x) &&
                            (i_item.start_y == i_item.end_y) &&
                            (i_item.start_z == i_item.end_z);
    end

    always_ff @(posedge i_clk) begin
        o_work <= n_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_push <= 1'b0;
        end else begin
            o_push <= i_accept;
        end
    end
endmodule
`default_nettype wire

@@ src/sch_back.sv @@
// back end: cross product, magnitudes by square root and the two distance tests
`default_nettype none
module sch_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire sch_pkg::t_work i_work,
    output logic                o_done,
    output sch_pkg::t_out       o_result
);
    import sch_pkg::*;
    localparam int CW    = COORD_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int EW    = ((PW > 64) ? PW : 64) + 1;
    localparam int CMPW  = (PW > 64) ? PW : 64;
    localparam int T_C   = 3;
    localparam int T_SUM = 6;
    localparam int T_LEN = T_SUM + 64;
    localparam int T_RV  = T_LEN + 2;
    localparam int LAT   = T_RV + 2;

    function automatic logic [63:0] sat_prod(input logic [PW-1:0] m, input logic neg);
        logic [EW-1:0] e;
        logic [63:0]   u;
        e = EW'(m);
        u = (e > EW'(SMAX)) ? SMAX : e[63:0];
        return neg ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [63:0] sat_cross(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] d;
        d = $signed({a[63], a}) - $signed({b[63], b});
        if (d > $signed({1'b0, SMAX})) begin
            return SMAX;
        end
        if (d < -$signed({1'b0, SMAX})) begin
            return ~SMAX + 1'b1;
        end
        return d[63:0];
    endfunction

    logic [LAT-1:0] r_vp;
    t_work          r_w0;

    logic [CW-1:0]  pa [6];
    logic [CW-1:0]  pb [6];
    logic [PW-1:0]  pp [6];
    logic [5:0]     neg0;
    logic [5:0]     neg2;
    logic [CW-1:0]  sa [5];
    logic [PW-1:0]  sq [5];

    logic [63:0]    r_c [3];
    logic [PW-1:0]  r_sv3;
    logic [PW-1:0]  r_svxz;
    logic [PW-1:0]  r_sdxz;
    logic [62:0]    cm [3];
    logic [125:0]   cs [3];
    logic [127:0]   r_sumc;

    logic [63:0]    clen;
    logic [CW-1:0]  vlen_e;
    logic [CW-1:0]  vxz_e;
    logic [CW-1:0]  dxz_e;
    logic [CW-1:0]  vlen;
    logic [CW-1:0]  vxz;
    logic [CW-1:0]  dxz;
    logic [RAD_WIDTH:0] sb_in;
    logic [RAD_WIDTH:0] sb_len;
    logic [RAD_WIDTH-1:0] rad;
    logic           reach;
    logic [65:0]    tail_in;
    logic [65:0]    tail_out;
    logic [PW-1:0]  rv;
    logic           near;

    always_ff @(posedge i_clk) begin
        r_w0 <= i_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[LAT-2:0], i_valid};
        end
    end

    always_comb begin
        pa[0] = mag(r_w0.v_y); pb[0] = mag(r_w0.d_z);
        pa[1] = mag(r_w0.v_z); pb[1] = mag(r_w0.d_y);
        pa[2] = mag(r_w0.v_z); pb[2] = mag(r_w0.d_x);
        pa[3] = mag(r_w0.v_x); pb[3] = mag(r_w0.d_z);
        pa[4] = mag(r_w0.v_x); pb[4] = mag(r_w0.d_y);
        pa[5] = mag(r_w0.v_y); pb[5] = mag(r_w0.d_x);
        neg0[0] = r_w0.v_y[CW-1] ^ r_w0.d_z[CW-1];
        neg0[1] = r_w0.v_z[CW-1] ^ r_w0.d_y[CW-1];
        neg0[2] = r_w0.v_z[CW-1] ^ r_w0.d_x[CW-1];
        neg0[3] = r_w0.v_x[CW-1] ^ r_w0.d_z[CW-1];
        neg0[4] = r_w0.v_x[CW-1] ^ r_w0.d_y[CW-1];
        neg0[5] = r_w0.v_y[CW-1] ^ r_w0.d_x[CW-1];
        sa[0] = mag(r_w0.v_x);
        sa[1] = mag(r_w0.v_y);
        sa[2] = mag(r_w0.v_z);
        sa[3] = mag(r_w0.d_x);
        sa[4] = mag(r_w0.d_z);
    end

    for (genvar k = 0; k < 6; k++) begin : g_prod
        sch_mult #(.W(CW)) u_mult (.i_clk(i_clk), .i_a(pa[k]), .i_b(pb[k]), .o_p(pp[k]));
    end

    for (genvar k = 0; k < 5; k++) begin : g_sq
        sch_mult #(.W(CW)) u_mult (.i_clk(i_clk), .i_a(sa[k]), .i_b(sa[k]), .o_p(sq[k]));
    end

    sch_delay #(.W(6), .N(2)) u_sign_dly (.i_clk(i_clk), .i_d(neg0), .o_q(neg2));

    always_ff @(posedge i_clk) begin
        r_c[0] <= sat_cross(sat_prod(pp[0], neg2[0]), sat_prod(pp[1], neg2[1]));
        r_c[1] <= sat_cross(sat_prod(pp[2], neg2[2]), sat_prod(pp[3], neg2[3]));
        r_c[2] <= sat_cross(sat_prod(pp[4], neg2[4]), sat_prod(pp[5], neg2[5]));
        r_sv3  <= sq[0] + sq[1] + sq[2];
        r_svxz <= sq[0] + sq[2];
        r_sdxz <= sq[3] + sq[4];
    end

    for (genvar k = 0; k < 3; k++) begin : g_csq
        logic [63:0] cu;
        assign cu    = r_c[k][63] ? (~r_c[k] + 1'b1) : r_c[k];
        assign cm[k] = cu[62:0];
        sch_mult #(.W(63)) u_mult (.i_clk(i_clk), .i_a(cm[k]), .i_b(cm[k]), .o_p(cs[k]));
    end

    always_ff @(posedge i_clk) begin
        r_sumc <= 128'(cs[0]) + 128'(cs[1]) + 128'(cs[2]);
    end

    sch_sqrt #(.OW(64)) u_sqrt_c (.i_clk(i_clk), .i_n(r_sumc), .o_root(clen));
    sch_sqrt #(.OW(CW)) u_sqrt_v (.i_clk(i_clk), .i_n(r_sv3), .o_root(vlen_e));
    sch_sqrt #(.OW(CW)) u_sqrt_vxz (.i_clk(i_clk), .i_n(r_svxz), .o_root(vxz_e));
    sch_sqrt #(.OW(CW)) u_sqrt_dxz (.i_clk(i_clk), .i_n(r_sdxz), .o_root(dxz_e));

    sch_delay #(.W(3*CW), .N(T_LEN - T_C - CW)) u_len_dly (
        .i_clk (i_clk),
        .i_d   ({vlen_e, vxz_e, dxz_e}),
        .o_q   ({vlen, vxz, dxz})
    );

    assign sb_in = {r_w0.radius, r_w0.degenerate};

    sch_delay #(.W(RAD_WIDTH+1), .N(T_LEN)) u_sb_dly (
        .i_clk (i_clk),
        .i_d   (sb_in),
        .o_q   (sb_len)
    );

    assign rad   = sb_len[RAD_WIDTH:1];
    assign reach = ((CW+1)'(vxz) + (CW+1)'(rad)) > (CW+1)'(dxz);

    sch_mult #(.W(CW)) u_rv (.i_clk(i_clk), .i_a(CW'(rad)), .i_b(vlen), .o_p(rv));

    assign tail_in = {clen, reach, sb_len[0]};

    sch_delay #(.W(66), .N(T_RV - T_LEN)) u_tail_dly (
        .i_clk (i_clk),
        .i_d   (tail_in),
        .o_q   (tail_out)
    );

    assign near = CMPW'(tail_out[65:2]) < CMPW'(rv);

    always_ff @(posedge i_clk) begin
        o_result.hit        <= !tail_out[0] && near && tail_out[1];
        o_result.degenerate <= tail_out[0];
    end

    assign o_done = r_vp[LAT-1];
endmodule
`default_nettype wire
